>>> hw/rtl/ymre_pkg.sv
// Shared types and constants for the YMODEM receive engine.
package ymre_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  CH_C          = 8'h43;
    localparam logic [7:0]  CH_ACK        = 8'h06;
    localparam logic [7:0]  CH_EOT        = 8'h04;
    localparam logic [7:0]  CH_SOH        = 8'h01;
    localparam logic [7:0]  CH_STX        = 8'h02;
    localparam logic [7:0]  CH_NAK        = 8'h15;
    localparam logic [7:0]  CH_CAN        = 8'h18;
    localparam logic [10:0] SHORT_LEN     = 11'd128;
    localparam logic [10:0] LONG_LEN      = 11'd1024;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [10:0] POS_MAX       = 11'd2047;
    localparam int          QDEPTH        = 4;
    localparam int          QAW           = 2;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_REPLY    = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED = 3'd2;
    localparam logic [2:0] KIND_FINISHED = 3'd3;
    localparam logic [2:0] KIND_FAILED   = 3'd4;

    localparam logic [1:0] FC_NONE    = 2'd0;
    localparam logic [1:0] FC_TIMEOUT = 2'd1;
    localparam logic [1:0] FC_CRC     = 2'd2;
    localparam logic [1:0] FC_HEADER  = 2'd3;

    typedef enum logic [2:0] {
        PH_SETUP_STR = 3'd0,
        PH_FIRST     = 3'd1,
        PH_DATA      = 3'd2,
        PH_END       = 3'd3,
        PH_DISC      = 3'd4,
        PH_IDLE      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [1:0] fail_code;
    } result_t;

    // Up to two results per request travel as one queue entry.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    function automatic logic [7:0] setup_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0: c = 8'h72;
                3'd1: c = 8'h62;
                3'd2: c = 8'h20;
                3'd3: c = 8'h2D;
                3'd4: c = 8'h45;
                default: c = 8'h72;
            endcase
            return c;
        end
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
            end
            return c;
        end
    endfunction

endpackage

>>> hw/rtl/ymodem_receive_engine_top.sv
// Top level of the YMODEM receive engine.
//
// The s_ channel takes one request per cycle while the queue has room:
// a received byte with its frame_end flag, a millisecond tick, or a
// session start. The front end updates the protocol state in the cycle
// of acceptance and writes zero or one entry (holding one or two
// results) into a four-entry queue. The m_ channel presents results
// straight from the queue head, once the registered entry of a request
// reaches it; m_last marks the final result of each request. A request
// with two results is presented one result at a time. When the receiver
// stalls, the queue fills and s_ready drops once all four entries are
// taken. The timeout register tmo_reg is written through cfg_we and
// cfg_wdata; the user must write it only while idle, as the block does
// not enforce this. Synchronous reset empties the queue, returns to
// waiting for the setup string and loads a timeout of 2000 ticks.
module ymodem_receive_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_value,
    output logic [1:0]  m_fail_code,
    output logic        m_last
);
    import ymre_pkg::*;

    logic   q_full, q_push, q_not_empty, q_pop;
    entry_t q_entry, q_head;

    ymre_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_command, .s_rx_byte, .s_frame_end,
        .q_full, .q_push, .q_entry
    );

    ymre_queue u_queue (
        .aclk, .aresetn,
        .push(q_push), .push_entry(q_entry), .full(q_full),
        .not_empty(q_not_empty), .pop(q_pop), .head(q_head)
    );

    ymre_back u_back (
        .aclk, .aresetn, .q_not_empty, .q_head, .q_pop,
        .m_valid, .m_ready, .m_kind, .m_value, .m_fail_code, .m_last
    );

    // Only failures carry a failure code.
    a_fc_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fail_code != FC_NONE |-> m_kind == KIND_FAILED)
        else $error("fail code on non-failure result");

    // A failure always ends its request.
    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_FAILED |-> m_last)
        else $error("failure not last");

    // The queue never takes a write while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overflow");

endmodule

>>> hw/rtl/ymre_front.sv
// Front end: accepts requests, tracks protocol state and builds result entries.
module ymre_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [7:0]        s_rx_byte,
    input  logic              s_frame_end,
    input  logic              q_full,
    output logic              q_push,
    output ymre_pkg::entry_t  q_entry
);
    import ymre_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [10:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [7:0]  bhdr_reg, bhdr_next;
    logic        long_reg, long_next;
    logic [7:0]  fhdr_reg, fhdr_next;
    logic [2:0]  match_reg, match_next;
    logic        seen_reg, seen_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] tmo_reg;

    logic        acc;
    logic [1:0]  n;
    result_t     r0, r1;
    logic [7:0]  hdr;
    logic [10:0] len;
    logic [11:0] pos_x, len_x;
    logic        crc_ok;
    logic [15:0] tick_inc;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmo_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            tmo_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SETUP_STR;
            pos_reg   <= '0;
            crc_reg   <= '0;
            rcrc_reg  <= '0;
            bhdr_reg  <= '0;
            long_reg  <= 1'b0;
            fhdr_reg  <= '0;
            match_reg <= '0;
            seen_reg  <= 1'b0;
            tick_reg  <= '0;
        end else if (acc) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            bhdr_reg  <= bhdr_next;
            long_reg  <= long_next;
            fhdr_reg  <= fhdr_next;
            match_reg <= match_next;
            seen_reg  <= seen_next;
            tick_reg  <= tick_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        bhdr_next  = bhdr_reg;
        long_next  = long_reg;
        fhdr_next  = fhdr_reg;
        match_next = match_reg;
        seen_next  = seen_reg;
        tick_next  = tick_reg;
        n          = 2'd0;
        r0         = '{kind: KIND_REPLY, value: 8'h00, fail_code: FC_NONE};
        r1         = '{kind: KIND_REPLY, value: 8'h00, fail_code: FC_NONE};
        hdr        = (pos_reg == 11'd0) ? s_rx_byte : fhdr_reg;
        if (phase_reg == PH_FIRST) begin
            len = (hdr == CH_STX) ? LONG_LEN : SHORT_LEN;
        end else begin
            len = long_reg ? LONG_LEN : SHORT_LEN;
        end
        pos_x    = {1'b0, pos_reg};
        len_x    = {1'b0, len};
        tick_inc = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;
        crc_ok   = 1'b0;

        if (s_command == CMD_START) begin
            phase_next = PH_SETUP_STR;
            pos_next   = '0;
            crc_next   = '0;
            rcrc_next  = '0;
            bhdr_next  = '0;
            long_next  = 1'b0;
            fhdr_next  = '0;
            match_next = '0;
            seen_next  = 1'b0;
            tick_next  = '0;
        end else if (s_command == CMD_TICK && phase_reg != PH_IDLE) begin
            tick_next = tick_inc;
            if (tick_inc >= tmo_reg) begin
                tick_next = '0;
                if (phase_reg == PH_SETUP_STR) begin
                    n  = 2'd1;
                    r0 = '{kind: KIND_REPLY, value: CH_C, fail_code: FC_NONE};
                end else if (phase_reg == PH_DATA) begin
                    n  = 2'd2;
                    r0 = '{kind: KIND_REPLY, value: CH_CAN, fail_code: FC_NONE};
                    r1 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_TIMEOUT};
                    phase_next = PH_IDLE;
                end else begin
                    n  = 2'd1;
                    r0 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_TIMEOUT};
                    phase_next = PH_IDLE;
                end
            end
        end else if (s_command == CMD_BYTE && phase_reg != PH_IDLE) begin
            if (pos_reg == 11'd0) begin
                fhdr_next = s_rx_byte;
            end
            if (phase_reg == PH_SETUP_STR) begin
                if (s_rx_byte == setup_char(match_reg)) begin
                    if (match_reg == 3'd4) begin
                        seen_next  = 1'b1;
                        match_next = '0;
                    end else begin
                        match_next = match_reg + 3'd1;
                    end
                end else begin
                    match_next = (s_rx_byte == setup_char(3'd0)) ? 3'd1 : 3'd0;
                end
            end else if (pos_x >= 12'd3 && pos_x < 12'd3 + len_x) begin
                crc_next = crc_byte(crc_reg, s_rx_byte);
                if (phase_reg == PH_DATA && fhdr_next == bhdr_reg && !s_frame_end) begin
                    n  = 2'd1;
                    r0 = '{kind: KIND_PAYLOAD, value: s_rx_byte, fail_code: FC_NONE};
                end
            end else if (pos_x == 12'd3 + len_x) begin
                rcrc_next = {s_rx_byte, rcrc_reg[7:0]};
            end else if (pos_x == 12'd4 + len_x) begin
                rcrc_next = {rcrc_reg[15:8], s_rx_byte};
            end
            pos_next = (pos_reg != POS_MAX) ? pos_reg + 11'd1 : pos_reg;

            if (s_frame_end) begin
                // A frame ending on a data byte never carries its CRC bytes.
                crc_ok = ({1'b0, pos_next} >= 12'd5 + len_x) && (crc_next == rcrc_next);
                case (phase_reg)
                    PH_SETUP_STR: begin
                        n  = 2'd1;
                        r0 = '{kind: KIND_REPLY, value: CH_C, fail_code: FC_NONE};
                        if (seen_next) begin
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST: begin
                        if (fhdr_next == 8'h00) begin
                            n = 2'd0;
                        end else if (fhdr_next == CH_SOH || fhdr_next == CH_STX) begin
                            bhdr_next = fhdr_next;
                            long_next = (fhdr_next == CH_STX);
                            n = 2'd1;
                            if (crc_ok) begin
                                r0 = '{kind: KIND_REPLY, value: CH_ACK, fail_code: FC_NONE};
                                phase_next = PH_DATA;
                            end else begin
                                r0 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_CRC};
                                phase_next = PH_IDLE;
                            end
                        end else begin
                            n  = 2'd1;
                            r0 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_HEADER};
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        // Frame end byte is never streamed, so slot 0 is free here.
                        if (fhdr_next == bhdr_reg) begin
                            n = 2'd2;
                            if (crc_ok) begin
                                r0 = '{kind: KIND_REPLY, value: CH_ACK, fail_code: FC_NONE};
                                r1 = '{kind: KIND_ACCEPTED, value: 8'h00, fail_code: FC_NONE};
                            end else begin
                                r0 = '{kind: KIND_REPLY, value: CH_CAN, fail_code: FC_NONE};
                                r1 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_CRC};
                                phase_next = PH_IDLE;
                            end
                        end else if (fhdr_next == CH_EOT) begin
                            n  = 2'd1;
                            r0 = '{kind: KIND_REPLY, value: CH_NAK, fail_code: FC_NONE};
                            phase_next = PH_END;
                        end else begin
                            n  = 2'd2;
                            r0 = '{kind: KIND_REPLY, value: CH_CAN, fail_code: FC_NONE};
                            r1 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_HEADER};
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_END: begin
                        if (fhdr_next == CH_EOT) begin
                            n  = 2'd2;
                            r0 = '{kind: KIND_REPLY, value: CH_ACK, fail_code: FC_NONE};
                            r1 = '{kind: KIND_REPLY, value: CH_C, fail_code: FC_NONE};
                            phase_next = PH_DISC;
                        end else begin
                            n  = 2'd1;
                            r0 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_HEADER};
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        if (fhdr_next == bhdr_reg) begin
                            n  = 2'd2;
                            r0 = '{kind: KIND_REPLY, value: CH_ACK, fail_code: FC_NONE};
                            r1 = '{kind: KIND_FINISHED, value: 8'h00, fail_code: FC_NONE};
                        end else begin
                            n  = 2'd1;
                            r0 = '{kind: KIND_FAILED, value: 8'h00, fail_code: FC_HEADER};
                        end
                        phase_next = PH_IDLE;
                    end
                endcase
                pos_next   = '0;
                crc_next   = '0;
                rcrc_next  = '0;
                fhdr_next  = '0;
                match_next = '0;
                seen_next  = 1'b0;
                tick_next  = '0;
            end
        end
    end

    assign q_push        = acc && (n != 2'd0);
    assign q_entry.two   = (n == 2'd2);
    assign q_entry.r0    = r0;
    assign q_entry.r1    = r1;

endmodule

>>> hw/rtl/ymre_queue.sv
// Short entry queue between the front end and the output stage.
module ymre_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ymre_pkg::entry_t push_entry,
    output logic             full,
    output logic             not_empty,
    input  logic             pop,
    output ymre_pkg::entry_t head
);
    import ymre_pkg::*;

    entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;

    assign full      = (cnt_reg == QAW'(0) + (QAW+1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + QAW'(1);
            end
            if (pop) begin
                rp_reg <= rp_reg + QAW'(1);
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

>>> hw/rtl/ymre_back.sv
// Back end: unpacks queue entries into single results on the output channel.
module ymre_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  ymre_pkg::entry_t q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_value,
    output logic [1:0]       m_fail_code,
    output logic             m_last
);
    import ymre_pkg::*;

    logic    second_reg;
    result_t cur;

    assign cur         = second_reg ? q_head.r1 : q_head.r0;
    assign m_valid     = q_not_empty;
    assign m_kind      = cur.kind;
    assign m_value     = cur.value;
    assign m_fail_code = cur.fail_code;
    assign m_last      = second_reg || !q_head.two;
    assign q_pop       = m_valid && m_ready && m_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            second_reg <= !m_last;
        end
    end

endmodule
